>>> sv/lgpt_pkg.sv
// ============================================================================
// lgpt_pkg
// Shared widths, constants, types and helper functions of the pose transform.
// ============================================================================
package lgpt_pkg;

    localparam int POS_WIDTH    = 40;
    localparam int CORDIC_STEPS = 30;

    localparam int ANG_W  = 23;
    localparam int BR_W   = 8;
    localparam int PPM_W  = 21;
    localparam int EV_W   = 32;

    // iteration index of the CORDIC loop
    localparam int CNT_W = $clog2(CORDIC_STEPS);

    // projection multiplier: magnitude of a position difference times a Q30 coefficient,
    // one DIG_W-bit digit per cycle
    localparam int DIG_W  = 16;
    localparam int MAG_W  = POS_WIDTH + 1;
    localparam int NCH    = (MAG_W + DIG_W - 1) / DIG_W;
    localparam int CH_W   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int OPW    = NCH * DIG_W;
    localparam int COEF_W = 32;
    localparam int TACC_W = OPW + COEF_W;
    localparam int ACC_W  = TACC_W + 2;
    localparam int QW     = ACC_W - 30;
    localparam int SUM_W  = QW + 1;

    // CORDIC datapath width (Q2.30 plus guard)
    localparam int CW = 34;

    localparam int PI_URAD   = 3141593;
    localparam int TURN_URAD = 6283185;

    localparam logic signed [ANG_W:0] ANG_HI   = (ANG_W + 1)'(PI_URAD - 1);
    localparam logic signed [ANG_W:0] ANG_LO   = -((ANG_W + 1)'(PI_URAD - 1));
    localparam logic signed [ANG_W:0] ANG_SPAN = (ANG_W + 1)'(TURN_URAD);

    // urad to Q30: q = floor(n * 2^24 / 15625), reciprocal with one correction step
    localparam int NMAG_W  = ANG_W - 1;
    localparam int RECIP_W = 33;
    localparam int RSH     = 22;
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(64'd70368744177664 / 64'd15625);
    localparam logic [13:0]        DIV_DEN   = 14'd15625;

    localparam logic signed [CW-1:0] HALF_PI_Q = CW'(64'sd1686629713);
    localparam logic signed [CW-1:0] PI_Q      = CW'(64'sd3373259426);
    localparam logic signed [CW-1:0] GAIN_Q    = CW'(64'sd652032874);

    localparam logic [19:0] PPM_SCALE = 20'd1000000;
    localparam logic [22:0] PPM_MAX   = 23'd1000000;

    localparam logic [1:0] TERM_LAST = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_DIV_MUL,
        ST_DIV_CHK,
        ST_DIV_FIX,
        ST_CORDIC_INIT,
        ST_CORDIC,
        ST_CORDIC_END,
        ST_PPM_COS,
        ST_PPM_SIN,
        ST_TERM_LOAD,
        ST_TERM_MUL,
        ST_TERM_ADD,
        ST_FIN,
        ST_DONE
    } lgpt_state_t;

    typedef struct packed {
        logic             load;
        logic             div_mul;
        logic             div_chk;
        logic             div_fix;
        logic             cordic_init;
        logic             cordic_step;
        logic             cordic_end;
        logic             ppm_cos;
        logic             ppm_sin;
        logic             term_load;
        logic             term_mul;
        logic             term_add;
        logic             fin;
        logic             out_load;
        logic [CNT_W-1:0] iter;
        logic [1:0]       term;
    } lgpt_cmd_t;

    typedef struct packed {
        logic act;
        logic match;
    } lgpt_status_t;

    // wrap an angle sum into [-3141592, 3141592] urad; inputs stay within one turn of range
    function automatic logic signed [ANG_W-1:0] norm_angle(input logic signed [ANG_W:0] a);
        logic signed [ANG_W:0] r;
        r = a;
        if (a > ANG_HI)
            r = a - ANG_SPAN;
        else if (a < ANG_LO)
            r = a + ANG_SPAN;
        return r[ANG_W-1:0];
    endfunction

    // atan(2^-i) in Q30, rounded to nearest
    function automatic logic [31:0] atan_q30(input logic [CNT_W-1:0] i);
        logic [31:0] v;
        case (int'(i))
            0:  v = 32'd843314857;
            1:  v = 32'd497837829;
            2:  v = 32'd263043837;
            3:  v = 32'd133525159;
            4:  v = 32'd67021687;
            5:  v = 32'd33543516;
            6:  v = 32'd16775851;
            7:  v = 32'd8388437;
            8:  v = 32'd4194283;
            9:  v = 32'd2097149;
            31: v = 32'd1;
            default:
            begin
                if (int'(i) <= 30)
                    v = 32'd1 << (30 - int'(i));
                else
                    v = 32'd0;
            end
        endcase
        return v;
    endfunction

endpackage

>>> sv/lgpt_ctrl.sv
// ============================================================================
// lgpt_ctrl
// Sequencer: handshakes, loop counters and datapath commands.
// ============================================================================
module lgpt_ctrl
    import lgpt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    input  lgpt_status_t status,
    output lgpt_cmd_t    cmd
);

    lgpt_state_t      state_reg, state_next;
    logic [CNT_W-1:0] iter_reg, iter_next;
    logic [CH_W-1:0]  chunk_reg, chunk_next;
    logic [1:0]       term_reg, term_next;
    logic             ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
            chunk_reg <= '0;
            term_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            chunk_reg <= chunk_next;
            term_reg  <= term_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        chunk_next = chunk_reg;
        term_next  = term_reg;
        cmd        = '0;
        cmd.iter   = iter_reg;
        cmd.term   = term_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                term_next = '0;
                if (status.act)
                    state_next = ST_DIV_MUL;
                else if (status.match)
                    state_next = ST_TERM_LOAD;
                else
                    state_next = ST_DONE;
            end
            ST_DIV_MUL:
            begin
                cmd.div_mul = 1'b1;
                state_next  = ST_DIV_CHK;
            end
            ST_DIV_CHK:
            begin
                cmd.div_chk = 1'b1;
                state_next  = ST_DIV_FIX;
            end
            ST_DIV_FIX:
            begin
                cmd.div_fix = 1'b1;
                state_next  = ST_CORDIC_INIT;
            end
            ST_CORDIC_INIT:
            begin
                cmd.cordic_init = 1'b1;
                iter_next       = '0;
                state_next      = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
                if (iter_reg == CNT_W'(CORDIC_STEPS - 1))
                    state_next = ST_CORDIC_END;
                else
                    iter_next = iter_reg + 1'b1;
            end
            ST_CORDIC_END:
            begin
                cmd.cordic_end = 1'b1;
                state_next     = ST_PPM_COS;
            end
            ST_PPM_COS:
            begin
                cmd.ppm_cos = 1'b1;
                state_next  = ST_PPM_SIN;
            end
            ST_PPM_SIN:
            begin
                cmd.ppm_sin = 1'b1;
                term_next   = '0;
                state_next  = status.match ? ST_TERM_LOAD : ST_DONE;
            end
            ST_TERM_LOAD:
            begin
                cmd.term_load = 1'b1;
                chunk_next    = '0;
                state_next    = ST_TERM_MUL;
            end
            ST_TERM_MUL:
            begin
                cmd.term_mul = 1'b1;
                if (chunk_reg == CH_W'(NCH - 1))
                    state_next = ST_TERM_ADD;
                else
                    chunk_next = chunk_reg + 1'b1;
            end
            ST_TERM_ADD:
            begin
                cmd.term_add = 1'b1;
                if (term_reg[0])
                    state_next = ST_FIN;
                else
                begin
                    term_next  = term_reg + 1'b1;
                    state_next = ST_TERM_LOAD;
                end
            end
            ST_FIN:
            begin
                cmd.fin = 1'b1;
                if (term_reg == TERM_LAST)
                    state_next = ST_DONE;
                else
                begin
                    term_next  = term_reg + 1'b1;
                    state_next = ST_TERM_LOAD;
                end
            end
            ST_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load)
            ov_next = 1'b1;
        else if (ov_reg && !out_stall)
            ov_next = 1'b0;
        else
            ov_next = ov_reg;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = ov_reg;

endmodule

>>> sv/lgpt_datapath.sv
// ============================================================================
// lgpt_datapath
// Transform state, urad-to-Q30 scaling, CORDIC, ppm rounding, projection MAC.
// ============================================================================
module lgpt_datapath
    import lgpt_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  lgpt_cmd_t                   cmd,
    output lgpt_status_t                status,

    input  logic                        func,
    input  logic                        pose_valid,
    input  logic signed [POS_WIDTH-1:0] pos_x,
    input  logic signed [POS_WIDTH-1:0] pos_y,
    input  logic signed [ANG_W-1:0]     pos_heading,
    input  logic [BR_W-1:0]             branch,
    input  logic signed [POS_WIDTH-1:0] ref_x,
    input  logic signed [POS_WIDTH-1:0] ref_y,
    input  logic signed [ANG_W-1:0]     ref_heading,
    input  logic                        ref_complete,
    input  logic                        seed_flag,

    output logic                        anchor_taken,
    output logic                        transform_present,
    output logic                        branch_match,
    output logic                        pose_out_valid,
    output logic signed [POS_WIDTH-1:0] glob_x,
    output logic signed [POS_WIDTH-1:0] glob_y,
    output logic signed [ANG_W-1:0]     glob_heading,
    output logic signed [ANG_W-1:0]     rotation_angle,
    output logic signed [PPM_W-1:0]     cos_ppm,
    output logic signed [PPM_W-1:0]     sin_ppm,
    output logic [EV_W-1:0]             anchor_seq
);

    // captured word
    logic                        it_pv_reg;
    logic signed [POS_WIDTH-1:0] it_px_reg, it_py_reg;
    logic signed [ANG_W-1:0]     it_ph_reg;
    logic [BR_W-1:0]             it_br_reg;
    logic                        act_reg;

    // transform state
    logic                        tv_reg;
    logic signed [POS_WIDTH-1:0] lref_x_reg, lref_y_reg, gref_x_reg, gref_y_reg;
    logic signed [ANG_W-1:0]     rot_reg;
    logic [BR_W-1:0]             rbr_reg;
    logic [EV_W-1:0]             next_ev_reg, last_ev_reg;
    logic signed [PPM_W-1:0]     acos_reg, asin_reg;
    logic signed [COEF_W-1:0]    cq_reg, sq_reg;

    // scaling and CORDIC
    logic [31:0]                 q_reg;
    logic [45:0]                 t_reg;
    logic signed [CW-1:0]        cx_reg, cy_reg, cz_reg;
    logic                        flip_reg;

    // projection
    logic [OPW-1:0]              op_reg;
    logic [COEF_W-1:0]           coef_reg;
    logic                        tneg_reg;
    logic [TACC_W-1:0]           tacc_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [POS_WIDTH-1:0] gx_reg, gy_reg;

    // ---------------- combinational ----------------
    logic                        act_w;
    logic signed [ANG_W-1:0]     lrh_w;
    logic signed [ANG_W-1:0]     rot_w;
    logic [NMAG_W-1:0]           nmag;
    logic [NMAG_W+RECIP_W-1:0]   recip_prod;
    logic [45:0]                 num_w, rem_w;
    logic signed [CW-1:0]        zq, zs;
    logic signed [CW-1:0]        xs, ys, at;
    logic signed [COEF_W-1:0]    ppm_src;
    logic [COEF_W-1:0]           ppm_mag;
    logic [COEF_W+19:0]          ppm_prod;
    logic [22:0]                 ppm_r;
    logic [22:0]                 ppm_c;
    logic signed [PPM_W-1:0]     ppm_val;
    logic signed [POS_WIDTH:0]   dx_w, dy_w, d_sel;
    logic signed [COEF_W-1:0]    coef_sel;
    logic [POS_WIDTH:0]          d_mag;
    logic [DIG_W+COEF_W-1:0]     chunk_prod;
    logic signed [ACC_W-1:0]     tacc_ext;
    logic signed [ACC_W-1:0]     acc_bias;
    logic signed [QW-1:0]        qv;
    logic signed [SUM_W-1:0]     fsum;
    logic signed [POS_WIDTH-1:0] fsat;
    logic                        match_w;

    assign act_w   = func & pose_valid & ref_complete;
    assign lrh_w   = seed_flag ? pos_heading : '0;
    assign rot_w   = norm_angle((ANG_W + 1)'(ref_heading) - (ANG_W + 1)'(lrh_w));
    assign match_w = it_pv_reg & tv_reg & (it_br_reg == rbr_reg);

    assign status.act   = act_reg;
    assign status.match = match_w;

    // |rotation| * 2^24 / 15625
    assign nmag       = rot_reg[ANG_W-1] ? NMAG_W'(-rot_reg) : NMAG_W'(rot_reg);
    assign recip_prod = nmag * DIV_RECIP;
    assign num_w      = {nmag, 24'd0};
    assign rem_w      = num_w - t_reg;
    assign zq         = $signed({2'b00, q_reg});
    assign zs         = rot_reg[ANG_W-1] ? -zq : zq;

    assign xs = cx_reg >>> cmd.iter;
    assign ys = cy_reg >>> cmd.iter;
    assign at = $signed({2'b00, atan_q30(cmd.iter)});

    // ppm rounding, half away from zero, clamped
    assign ppm_src  = cmd.ppm_sin ? sq_reg : cq_reg;
    assign ppm_mag  = ppm_src[COEF_W-1] ? COEF_W'(-ppm_src) : COEF_W'(ppm_src);
    assign ppm_prod = ppm_mag * PPM_SCALE;
    assign ppm_r    = 23'((ppm_prod + (COEF_W + 20)'(1 << 29)) >> 30);
    assign ppm_c    = (ppm_r > PPM_MAX) ? PPM_MAX : ppm_r;
    assign ppm_val  = ppm_src[COEF_W-1] ? -$signed(PPM_W'(ppm_c)) : $signed(PPM_W'(ppm_c));

    // term 0: dx*c, 1: -dy*s, 2: dx*s, 3: dy*c
    assign dx_w     = (POS_WIDTH + 1)'(it_px_reg) - (POS_WIDTH + 1)'(lref_x_reg);
    assign dy_w     = (POS_WIDTH + 1)'(it_py_reg) - (POS_WIDTH + 1)'(lref_y_reg);
    assign d_sel    = cmd.term[0] ? dy_w : dx_w;
    assign coef_sel = (cmd.term[0] ^ cmd.term[1]) ? sq_reg : cq_reg;
    assign d_mag    = d_sel[POS_WIDTH] ? (POS_WIDTH + 1)'(-d_sel) : (POS_WIDTH + 1)'(d_sel);

    assign chunk_prod = op_reg[OPW-1 -: DIG_W] * coef_reg;
    assign tacc_ext   = $signed({2'b00, tacc_reg});

    // divide by 2^30 toward zero, add reference, saturate
    assign acc_bias = acc_reg + (acc_reg[ACC_W-1] ? ACC_W'(32'h3FFF_FFFF) : ACC_W'(0));
    assign qv       = acc_bias[ACC_W-1:30];
    assign fsum     = SUM_W'(qv) + SUM_W'(cmd.term[1] ? gref_y_reg : gref_x_reg);

    always_comb
    begin
        if (fsum > SUM_W'($signed({1'b0, {(POS_WIDTH - 1){1'b1}}})))
            fsat = $signed({1'b0, {(POS_WIDTH - 1){1'b1}}});
        else if (fsum < SUM_W'($signed({1'b1, {(POS_WIDTH - 1){1'b0}}})))
            fsat = $signed({1'b1, {(POS_WIDTH - 1){1'b0}}});
        else
            fsat = fsum[POS_WIDTH-1:0];
    end

    // ---------------- state with reset values ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg      <= 1'b0;
            rot_reg     <= '0;
            rbr_reg     <= '0;
            next_ev_reg <= EV_W'(1);
            last_ev_reg <= '0;
            acos_reg    <= '0;
            asin_reg    <= '0;
        end
        else
        begin
            if (cmd.load && act_w)
            begin
                tv_reg      <= 1'b1;
                rot_reg     <= rot_w;
                rbr_reg     <= branch;
                last_ev_reg <= next_ev_reg;
                next_ev_reg <= next_ev_reg + 1'b1;
            end
            if (cmd.ppm_cos)
                acos_reg <= ppm_val;
            if (cmd.ppm_sin)
                asin_reg <= ppm_val;
        end
    end

    // ---------------- working registers ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            it_pv_reg <= pose_valid;
            it_px_reg <= pos_x;
            it_py_reg <= pos_y;
            it_ph_reg <= pos_heading;
            it_br_reg <= branch;
            act_reg   <= act_w;
            acc_reg   <= '0;
            if (act_w)
            begin
                lref_x_reg <= seed_flag ? pos_x : '0;
                lref_y_reg <= seed_flag ? pos_y : '0;
                gref_x_reg <= ref_x;
                gref_y_reg <= ref_y;
            end
        end

        if (cmd.div_mul)
            q_reg <= recip_prod[RSH+31:RSH];
        if (cmd.div_chk)
            t_reg <= q_reg * DIV_DEN;
        if (cmd.div_fix)
            q_reg <= q_reg + {31'd0, (rem_w >= 46'(DIV_DEN))};

        if (cmd.cordic_init)
        begin
            cx_reg <= GAIN_Q;
            cy_reg <= '0;
            if (zs > HALF_PI_Q)
            begin
                cz_reg   <= zs - PI_Q;
                flip_reg <= 1'b1;
            end
            else if (zs < -HALF_PI_Q)
            begin
                cz_reg   <= zs + PI_Q;
                flip_reg <= 1'b1;
            end
            else
            begin
                cz_reg   <= zs;
                flip_reg <= 1'b0;
            end
        end
        if (cmd.cordic_step)
        begin
            if (!cz_reg[CW-1])
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - at;
            end
            else
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + at;
            end
        end
        if (cmd.cordic_end)
        begin
            cq_reg <= flip_reg ? COEF_W'(-cx_reg) : COEF_W'(cx_reg);
            sq_reg <= flip_reg ? COEF_W'(-cy_reg) : COEF_W'(cy_reg);
        end

        if (cmd.term_load)
        begin
            op_reg   <= OPW'(d_mag);
            coef_reg <= coef_sel[COEF_W-1] ? COEF_W'(-coef_sel) : COEF_W'(coef_sel);
            tneg_reg <= d_sel[POS_WIDTH] ^ coef_sel[COEF_W-1] ^ (cmd.term == 2'd1);
            tacc_reg <= '0;
        end
        if (cmd.term_mul)
        begin
            tacc_reg <= (tacc_reg << DIG_W) + TACC_W'(chunk_prod);
            op_reg   <= op_reg << DIG_W;
        end
        if (cmd.term_add)
            acc_reg <= tneg_reg ? (acc_reg - tacc_ext) : (acc_reg + tacc_ext);
        if (cmd.fin)
        begin
            if (cmd.term[1])
                gy_reg <= fsat;
            else
                gx_reg <= fsat;
            acc_reg <= '0;
        end

        if (cmd.out_load)
        begin
            anchor_taken        <= act_reg;
            transform_present   <= it_pv_reg & tv_reg;
            branch_match        <= match_w;
            pose_out_valid      <= match_w;
            glob_x              <= match_w ? gx_reg : '0;
            glob_y              <= match_w ? gy_reg : '0;
            glob_heading        <= match_w ?
                norm_angle((ANG_W + 1)'(it_ph_reg) + (ANG_W + 1)'(rot_reg)) : '0;
            rotation_angle      <= rot_reg;
            cos_ppm             <= acos_reg;
            sin_ppm             <= asin_reg;
            anchor_seq          <= last_ev_reg;
        end
    end

endmodule

>>> sv/local_to_global_pose_transform_unit.sv
// ============================================================================
// local_to_global_pose_transform_unit
// 2-D rigid transform of local poses into the global frame, with activation.
// ============================================================================
//
//  channel | handshake              | word
//  --------+------------------------+-----------------------------------------
//  input   | in_valid / in_stall    | func, pose and reference fields
//  output  | out_valid / out_stall  | flags, global pose, rotation, ppm, id
//
//  An activation runs the scaling, the serial CORDIC loop and ppm rounding;
//  a word with a valid pose whose branch matches the held transform then runs
//  the projection: four terms of NCH digit passes each in the digit-serial
//  multiplier (3 at 40-bit positions). Other words go to the output register.
//  One word is in work at a time; the next is taken in the cycle after the
//  result moves into the output register, which holds it while stalled.
//  Reset is asynchronous, active low; no clearing pass is needed.
//
module local_to_global_pose_transform_unit
    import lgpt_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        func,
    input  logic                        pose_valid,
    input  logic signed [POS_WIDTH-1:0] pos_x,
    input  logic signed [POS_WIDTH-1:0] pos_y,
    input  logic signed [ANG_W-1:0]     pos_heading,
    input  logic [BR_W-1:0]             branch,
    input  logic signed [POS_WIDTH-1:0] ref_x,
    input  logic signed [POS_WIDTH-1:0] ref_y,
    input  logic signed [ANG_W-1:0]     ref_heading,
    input  logic                        ref_complete,
    input  logic                        seed_flag,

    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        anchor_taken,
    output logic                        transform_present,
    output logic                        branch_match,
    output logic                        pose_out_valid,
    output logic signed [POS_WIDTH-1:0] glob_x,
    output logic signed [POS_WIDTH-1:0] glob_y,
    output logic signed [ANG_W-1:0]     glob_heading,
    output logic signed [ANG_W-1:0]     rotation_angle,
    output logic signed [PPM_W-1:0]     cos_ppm,
    output logic signed [PPM_W-1:0]     sin_ppm,
    output logic [EV_W-1:0]             anchor_seq
);

    lgpt_cmd_t    cmd;
    lgpt_status_t status;

    // sequencer: accepts a word in idle, steps the datapath, owns out_valid
    lgpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: transform state, CORDIC, projection and output register
    lgpt_datapath u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .func                (func),
        .pose_valid          (pose_valid),
        .pos_x               (pos_x),
        .pos_y               (pos_y),
        .pos_heading         (pos_heading),
        .branch              (branch),
        .ref_x               (ref_x),
        .ref_y               (ref_y),
        .ref_heading         (ref_heading),
        .ref_complete        (ref_complete),
        .seed_flag           (seed_flag),
        .anchor_taken        (anchor_taken),
        .transform_present   (transform_present),
        .branch_match        (branch_match),
        .pose_out_valid      (pose_out_valid),
        .glob_x              (glob_x),
        .glob_y              (glob_y),
        .glob_heading        (glob_heading),
        .rotation_angle      (rotation_angle),
        .cos_ppm             (cos_ppm),
        .sin_ppm             (sin_ppm),
        .anchor_seq          (anchor_seq)
    );

endmodule
